// ===== rtl/gb3_pkg.sv =====
// Shared constants and types for the 3x3 Gaussian blur stream core.
package gb3_pkg;

    // Line store depth: longest image row the core can hold.
    localparam int MAX_WIDTH = 1024;
    localparam int COL_W     = $clog2(MAX_WIDTH);

    // Configuration register fields.
    localparam int WEIGHT_W  = 16;
    localparam int WIDTH_W   = 11;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = WEIGHT_W;

    // Row-length arithmetic wide enough for both the register and MAX_WIDTH.
    localparam int LEN_W = (COL_W + 1 > WIDTH_W) ? COL_W + 1 : WIDTH_W;

    localparam logic [WEIGHT_W-1:0] CENTER_RESET = 16'd10081;
    localparam logic [WEIGHT_W-1:0] EDGE_RESET   = 16'd7811;
    localparam logic [WEIGHT_W-1:0] CORNER_RESET = 16'd6053;
    localparam logic [WIDTH_W-1:0]  WIDTH_RESET  = 11'd1024;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_CENTER = 2'd0,
        CFG_EDGE   = 2'd1,
        CFG_CORNER = 2'd2,
        CFG_WIDTH  = 2'd3
    } t_cfg_index;

    localparam int PIX_W = 8;
    localparam int SUM_W = 10;  // sum of four pixels

    // Operand queue between the window stage and the multiply stage.
    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
    localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

    localparam int PC_W  = WEIGHT_W + PIX_W;
    localparam int PS_W  = WEIGHT_W + SUM_W;
    localparam int ACC_W = PS_W + 2;

    typedef struct packed {
        logic [PIX_W-1:0] center;
        logic [SUM_W-1:0] sides;
        logic [SUM_W-1:0] corners;
        logic             frame_end;
    } t_opnd;

endpackage

// ===== rtl/gaussian_blur_3x3_stream_core.sv =====
// 3x3 Gaussian blur core: takes one 8-bit grayscale pixel per clock in raster order and
// returns each pixel blurred by the programmable weights (center, four sides, four corners,
// unsigned Q0.16), truncated by 16 bits and clamped to 255; pixels outside the image count
// as zero. Words in: tuser=0 image pixel, tuser=1 drain word (a zero pixel). Results for
// row r-1 come out while row r streams in, so after the last image row send one full row
// of drain words; the bottom-right result carries tlast. Throughput is one word per clock
// sustained while the output is not stalled: the last pixel of a row yields two results,
// which a four-entry operand queue absorbs against the empty first column of the next row.
// The first result of an accepted word passes the window and queue, multiply, and sum and
// clamp stages in turn; the second result of a row's last word follows right behind it.
// The line stores need no clearing after reset; write registers only while the core is idle.
module gaussian_blur_3x3_stream_core (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // configuration write port
    input  logic                            i_cfg_we,
    input  logic [gb3_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [gb3_pkg::CFG_DATA_W-1:0]  i_cfg_wdata,
    // input stream
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    input  logic [7:0]                      s_axis_tdata,   // [7:0] pixel
    input  logic                            s_axis_tuser,   // [0] command (1 = drain)
    // output stream
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    output logic [7:0]                      m_axis_tdata,   // [7:0] blurred_pixel
    output logic                            m_axis_tlast    // frame_end
);

    import gb3_pkg::*;

    // configuration
    logic [WEIGHT_W-1:0] r_w_center;
    logic [WEIGHT_W-1:0] r_w_edge;
    logic [WEIGHT_W-1:0] r_w_corner;
    logic [WIDTH_W-1:0]  r_width;

    // frame position
    logic [COL_W-1:0] r_col;
    logic [1:0]       r_rows;
    logic             r_draining;

    // window stage
    logic             r_s1_valid;
    logic [PIX_W-1:0] r_s1_value;
    logic [COL_W-1:0] r_s1_col;
    logic [1:0]       r_s1_rows;
    logic             r_s1_last;
    logic             r_s1_fe;
    logic             r_fwd;
    logic [PIX_W-1:0] r_fwd_above;
    logic [PIX_W-1:0] r_fwd_two;
    logic [PIX_W-1:0] r_win [6];

    // operand queue
    t_opnd                 r_fifo [FIFO_DEPTH];
    logic [FIFO_PTR_W-1:0] r_wr_ptr;
    logic [FIFO_PTR_W-1:0] r_rd_ptr;
    logic [FIFO_CNT_W-1:0] r_fifo_count;

    // multiply and output stages
    logic             r_m1_valid;
    logic [PC_W-1:0]  r_m1_pc;
    logic [PS_W-1:0]  r_m1_pe;
    logic [PS_W-1:0]  r_m1_pk;
    logic             r_m1_fe;
    logic             r_out_valid;
    logic [PIX_W-1:0] r_out_pix;
    logic             r_out_fe;

    // ------------------------------------------------------------------
    // Accept side: row position and line store read
    // ------------------------------------------------------------------
    logic             s_accept;
    logic             s1_fire;
    logic [LEN_W-1:0] width_ext;
    logic [LEN_W-1:0] width_eff;
    logic             last_now;
    logic             drain_now;
    logic [PIX_W-1:0] value_now;
    logic [PIX_W-1:0] ram_above_q;
    logic [PIX_W-1:0] ram_two_q;

    assign s1_fire       = r_s1_valid && (r_fifo_count <= FIFO_CNT_W'(FIFO_DEPTH - 2));
    assign s_axis_tready = !r_s1_valid || s1_fire;
    assign s_accept      = s_axis_tvalid && s_axis_tready;

    always_comb begin
        width_ext = LEN_W'(r_width);
        if (width_ext == '0) begin
            width_eff = LEN_W'(1);
        end else if (width_ext > LEN_W'(MAX_WIDTH)) begin
            width_eff = LEN_W'(MAX_WIDTH);
        end else begin
            width_eff = width_ext;
        end
    end

    assign last_now  = (LEN_W'(r_col) + LEN_W'(1)) >= width_eff;
    assign drain_now = r_draining || s_axis_tuser;
    assign value_now = s_axis_tuser ? '0 : s_axis_tdata;

    // ------------------------------------------------------------------
    // Window stage
    // ------------------------------------------------------------------
    logic [PIX_W-1:0] s1_above;
    logic [PIX_W-1:0] s1_two;
    logic [PIX_W-1:0] newcol [3];
    logic [PIX_W-1:0] left [3];
    logic [PIX_W-1:0] mid [3];
    logic             valid_a;
    logic             valid_b;
    t_opnd            opnd_a;
    t_opnd            opnd_b;
    t_opnd            push0;
    logic [1:0]       push_n;

    // same-address write and read in one cycle only happens for one-pixel rows
    assign s1_above = r_fwd ? r_fwd_above : ram_above_q;
    assign s1_two   = r_fwd ? r_fwd_two   : ram_two_q;

    always_comb begin
        newcol[0] = (r_s1_rows >= 2'd2) ? s1_two   : '0;
        newcol[1] = (r_s1_rows >= 2'd1) ? s1_above : '0;
        newcol[2] = r_s1_value;
        for (int k = 0; k < 3; k++) begin
            left[k] = (r_s1_col == '0) ? '0 : r_win[k];
            mid[k]  = (r_s1_col == '0) ? '0 : r_win[k+3];
        end

        valid_a = (r_s1_rows != 2'd0) && (r_s1_col != '0);
        valid_b = (r_s1_rows != 2'd0) && r_s1_last;

        opnd_a.center    = mid[1];
        opnd_a.sides     = SUM_W'(mid[0]) + SUM_W'(mid[2]) + SUM_W'(left[1]) + SUM_W'(newcol[1]);
        opnd_a.corners   = SUM_W'(left[0]) + SUM_W'(left[2])
                         + SUM_W'(newcol[0]) + SUM_W'(newcol[2]);
        opnd_a.frame_end = 1'b0;

        // right neighbor column is zero
        opnd_b.center    = newcol[1];
        opnd_b.sides     = SUM_W'(newcol[0]) + SUM_W'(newcol[2]) + SUM_W'(mid[1]);
        opnd_b.corners   = SUM_W'(mid[0]) + SUM_W'(mid[2]);
        opnd_b.frame_end = r_s1_fe;

        push0  = valid_a ? opnd_a : opnd_b;
        push_n = s1_fire ? (2'(valid_a) + 2'(valid_b)) : 2'd0;
    end

    gb3_ram #(
        .WIDTH (PIX_W),
        .DEPTH (MAX_WIDTH)
    ) u_line_above (
        .i_clk   (i_clk),
        .i_we    (s1_fire),
        .i_waddr (r_s1_col),
        .i_wdata (r_s1_value),
        .i_re    (s_accept),
        .i_raddr (r_col),
        .o_rdata (ram_above_q)
    );

    gb3_ram #(
        .WIDTH (PIX_W),
        .DEPTH (MAX_WIDTH)
    ) u_line_two_above (
        .i_clk   (i_clk),
        .i_we    (s1_fire),
        .i_waddr (r_s1_col),
        .i_wdata (s1_above),
        .i_re    (s_accept),
        .i_raddr (r_col),
        .o_rdata (ram_two_q)
    );

    // ------------------------------------------------------------------
    // Operand queue and arithmetic
    // ------------------------------------------------------------------
    logic        out_slot_free;
    logic        pop;
    t_opnd       head;
    logic [ACC_W-1:0] acc;

    assign out_slot_free = !r_out_valid || m_axis_tready;
    assign pop           = (r_fifo_count != '0) && (!r_m1_valid || out_slot_free);
    assign head          = r_fifo[r_rd_ptr];
    assign acc           = ACC_W'(r_m1_pc) + ACC_W'(r_m1_pe) + ACC_W'(r_m1_pk);

    // ------------------------------------------------------------------
    // Control registers
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_w_center   <= CENTER_RESET;
            r_w_edge     <= EDGE_RESET;
            r_w_corner   <= CORNER_RESET;
            r_width      <= WIDTH_RESET;
            r_col        <= '0;
            r_rows       <= 2'd0;
            r_draining   <= 1'b0;
            r_s1_valid   <= 1'b0;
            r_wr_ptr     <= '0;
            r_rd_ptr     <= '0;
            r_fifo_count <= '0;
            r_m1_valid   <= 1'b0;
            r_out_valid  <= 1'b0;
            for (int k = 0; k < 6; k++) begin
                r_win[k] <= '0;
            end
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_CENTER: r_w_center <= i_cfg_wdata;
                    CFG_EDGE:   r_w_edge   <= i_cfg_wdata;
                    CFG_CORNER: r_w_corner <= i_cfg_wdata;
                    CFG_WIDTH:  r_width    <= i_cfg_wdata[WIDTH_W-1:0];
                    default: ;
                endcase
            end

            if (s_accept) begin
                if (last_now) begin
                    r_col <= '0;
                    if (drain_now) begin
                        r_rows     <= 2'd0;
                        r_draining <= 1'b0;
                    end else if (r_rows < 2'd2) begin
                        r_rows <= r_rows + 2'd1;
                    end
                end else begin
                    r_col      <= r_col + COL_W'(1);
                    r_draining <= drain_now;
                end
            end

            if (s_accept) begin
                r_s1_valid <= 1'b1;
            end else if (s1_fire) begin
                r_s1_valid <= 1'b0;
            end

            // shift the window by one column
            if (s1_fire) begin
                for (int k = 0; k < 3; k++) begin
                    r_win[k]   <= mid[k];
                    r_win[k+3] <= newcol[k];
                end
            end

            r_wr_ptr     <= r_wr_ptr + FIFO_PTR_W'(push_n);
            r_rd_ptr     <= r_rd_ptr + FIFO_PTR_W'(pop);
            r_fifo_count <= r_fifo_count + FIFO_CNT_W'(push_n) - FIFO_CNT_W'(pop);

            r_m1_valid  <= pop || (r_m1_valid && !out_slot_free);
            r_out_valid <= (r_m1_valid && out_slot_free) || (r_out_valid && !m_axis_tready);
        end
    end

    // ------------------------------------------------------------------
    // Payload registers
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (s_accept) begin
            r_s1_value  <= value_now;
            r_s1_col    <= r_col;
            r_s1_rows   <= r_rows;
            r_s1_last   <= last_now;
            r_s1_fe     <= last_now && drain_now;
            r_fwd       <= r_s1_valid && (r_s1_col == r_col);
            r_fwd_above <= r_s1_value;
            r_fwd_two   <= s1_above;
        end

        if (push_n != 2'd0) begin
            r_fifo[r_wr_ptr] <= push0;
        end
        if (push_n == 2'd2) begin
            r_fifo[r_wr_ptr + FIFO_PTR_W'(1)] <= opnd_b;
        end

        if (pop) begin
            r_m1_pc <= PC_W'(r_w_center) * PC_W'(head.center);
            r_m1_pe <= PS_W'(r_w_edge) * PS_W'(head.sides);
            r_m1_pk <= PS_W'(r_w_corner) * PS_W'(head.corners);
            r_m1_fe <= head.frame_end;
        end

        // drop the fraction, clamp to the pixel range
        if (r_m1_valid && out_slot_free) begin
            r_out_pix <= (acc[ACC_W-1:WEIGHT_W+PIX_W] != '0) ? '1
                                                              : acc[WEIGHT_W+PIX_W-1:WEIGHT_W];
            r_out_fe  <= r_m1_fe;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_pix;
    assign m_axis_tlast  = r_out_fe;

`ifndef NO_ASSERTIONS
    a_fifo_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fifo_count <= FIFO_CNT_W'(FIFO_DEPTH))
        else $error("operand queue overflow");

    a_rows_sat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_rows != 2'd3)
        else $error("row counter passed saturation");

    a_drain_midrow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_draining |-> (r_col != '0))
        else $error("drain flag set at row start");

    a_frame_close: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_accept && last_now && drain_now) |=> (r_rows == 2'd0 && !r_draining && r_col == '0))
        else $error("frame state not cleared after drain row");
`endif

endmodule

// ===== rtl/gb3_ram.sv =====
// Simple dual-port RAM: one write port, one registered read port.
module gb3_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== test/tb_top.sv =====
// Self-checking testbench for the 3x3 Gaussian blur stream core.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;
    import gb3_pkg::*;

    localparam int QUIET_LIMIT   = 4000;
    localparam int SETTLE_CYCLES = 16;
    localparam int RANDOM_WORDS  = 520;
    localparam int PHASE_WORDS   = 120;

    typedef struct packed {
        logic [7:0] level;
        logic       frame_end;
    } t_blur_word;

    class t_blur_scoreboard;
        bit [WEIGHT_W-1:0] center_w;
        bit [WEIGHT_W-1:0] side_w;
        bit [WEIGHT_W-1:0] corner_w;
        bit [WIDTH_W-1:0]  width_reg;
        bit [7:0]          above_row [MAX_WIDTH];
        bit [7:0]          two_above_row [MAX_WIDTH];
        bit [2:0][7:0]     win_left;    // column c-2: [0] top, [1] middle, [2] bottom
        bit [2:0][7:0]     win_mid;     // column c-1
        int unsigned       col;
        int unsigned       rows_seen;
        bit                draining;
        t_blur_word        expected_blurs [$];
        int                errors;

        function new();
            center_w  = CENTER_RESET;
            side_w    = EDGE_RESET;
            corner_w  = CORNER_RESET;
            width_reg = WIDTH_RESET;
            win_left  = '0;
            win_mid   = '0;
            col       = 0;
            rows_seen = 0;
            draining  = 1'b0;
            errors    = 0;
        endfunction

        function void set_regs(bit [WEIGHT_W-1:0] c_w, bit [WEIGHT_W-1:0] s_w,
                               bit [WEIGHT_W-1:0] k_w, bit [WIDTH_W-1:0] len);
            center_w  = c_w;
            side_w    = s_w;
            corner_w  = k_w;
            width_reg = len;
        endfunction

        function int unsigned row_len();
            if (width_reg == 0) return 1;
            if (width_reg > MAX_WIDTH) return MAX_WIDTH;
            return width_reg;
        endfunction

        function bit at_frame_start();
            return col == 0 && rows_seen == 0;
        endfunction

        function bit [7:0] blur_at(bit [2:0][7:0] l, bit [2:0][7:0] m, bit [2:0][7:0] r);
            longint unsigned sides;
            longint unsigned corners;
            longint unsigned acc;
            sides   = 64'(m[0]) + 64'(m[2]) + 64'(l[1]) + 64'(r[1]);
            corners = 64'(l[0]) + 64'(l[2]) + 64'(r[0]) + 64'(r[2]);
            acc = 64'(center_w) * 64'(m[1]) + 64'(side_w) * sides
                + 64'(corner_w) * corners;
            acc = acc >> 16;
            return (acc > 255) ? 8'd255 : acc[7:0];
        endfunction

        function void note_word(bit drain, bit [7:0] pix);
            int unsigned   len;
            int unsigned   c;
            bit [7:0]      level;
            bit [2:0][7:0] fresh;
            bit            row_done;
            t_blur_word    outs [2];
            int            n;
            len = row_len();
            c = (col >= MAX_WIDTH) ? MAX_WIDTH - 1 : col;
            n = 0;
            if (drain) begin
                level = 8'd0;
                draining = 1'b1;
            end else begin
                level = pix;
            end
            if (c == 0) begin
                win_left = '0;
                win_mid  = '0;
            end
            fresh[0] = (rows_seen >= 2) ? two_above_row[c] : 8'd0;
            fresh[1] = (rows_seen >= 1) ? above_row[c] : 8'd0;
            fresh[2] = level;
            row_done = (c + 1 >= len);
            if (rows_seen >= 1) begin
                if (c >= 1) begin
                    outs[n].level = blur_at(win_left, win_mid, fresh);
                    outs[n].frame_end = 1'b0;
                    n++;
                end
                // last column: right neighbor lies outside the image
                if (row_done) begin
                    outs[n].level = blur_at(win_mid, fresh, '0);
                    outs[n].frame_end = 1'b0;
                    n++;
                end
            end
            win_left = win_mid;
            win_mid  = fresh;
            two_above_row[c] = above_row[c];
            above_row[c] = level;
            if (row_done) begin
                col = 0;
                if (draining) begin
                    if (n > 0) outs[n-1].frame_end = 1'b1;
                    rows_seen = 0;
                    draining  = 1'b0;
                    win_left  = '0;
                    win_mid   = '0;
                end else if (rows_seen < 2) begin
                    rows_seen++;
                end
            end else begin
                col = c + 1;
            end
            for (int i = 0; i < n; i++) expected_blurs.push_back(outs[i]);
        endfunction

        function void check_word(logic [7:0] level, logic fend);
            t_blur_word want;
            if (expected_blurs.size() == 0) begin
                $display("%0t: unexpected word: blurred_pixel %0d frame_end %0b",
                         $time, level, fend);
                errors++;
                return;
            end
            want = expected_blurs.pop_front();
            if (want.level !== level) begin
                $display("%0t: blurred_pixel expected %0d got %0d", $time, want.level, level);
                errors++;
            end
            if (want.frame_end !== fend) begin
                $display("%0t: frame_end expected %0b got %0b", $time, want.frame_end, fend);
                errors++;
            end
        endfunction
    endclass

    logic                  i_clk;
    logic                  i_rst_n       = 1'b0;
    logic                  i_cfg_we      = 1'b0;
    t_cfg_index            i_cfg_index   = CFG_CENTER;
    logic [CFG_DATA_W-1:0] i_cfg_wdata   = '0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [7:0]            s_axis_tdata  = '0;   // [7:0] pixel
    logic                  s_axis_tuser  = 1'b0; // [0] command (1 = drain)
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [7:0]            m_axis_tdata;         // [7:0] blurred_pixel
    logic                  m_axis_tlast;         // frame_end

    t_blur_scoreboard blur_sb = new();
    int src_gap_pct   = 0;
    int dst_stall_pct = 0;
    int words_sent    = 0;
    int quiet_cycles  = 0;

    gaussian_blur_3x3_stream_core u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_wdata   (i_cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // Receiver: stall at random, check every accepted word.
    always @(posedge i_clk) begin
        m_axis_tready <= ($urandom_range(99) >= dst_stall_pct);
        if (i_rst_n && m_axis_tvalid && m_axis_tready)
            blur_sb.check_word(m_axis_tdata, m_axis_tlast);
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles == QUIET_LIMIT) begin
            $display("tb_top: FAIL");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    function automatic bit [7:0] rand_pixel();
        case ($urandom_range(7))
            0: return 8'd0;
            1: return 8'd255;
            default: return 8'($urandom);
        endcase
    endfunction

    function automatic bit [WEIGHT_W-1:0] pick_weight();
        case ($urandom_range(3))
            0: return '0;
            1: return '1;
            2: return WEIGHT_W'($urandom_range(0, 12000));
            default: return WEIGHT_W'($urandom);
        endcase
    endfunction

    function automatic bit [WIDTH_W-1:0] pick_width();
        case ($urandom_range(9))
            0: return WIDTH_W'(1);
            1: return WIDTH_W'($urandom_range(13, 48));
            default: return WIDTH_W'($urandom_range(2, 12));
        endcase
    endfunction

    task automatic idle_mix(input int src_pct, input int dst_pct);
        src_gap_pct   = src_pct;
        dst_stall_pct = dst_pct;
    endtask

    // Hold the word until tready; tvalid stays high into the next word unless a gap is drawn.
    task automatic send_word(input bit drain, input bit [7:0] pix);
        if ($urandom_range(99) < src_gap_pct) begin
            s_axis_tvalid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < src_gap_pct);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= drain;
        s_axis_tdata  <= pix;
        do @(posedge i_clk); while (!s_axis_tready);
        blur_sb.note_word(drain, pix);
        words_sent++;
    endtask

    // Drop tvalid, wait for every outstanding result, then let the pipeline drain.
    task automatic settle();
        s_axis_tvalid <= 1'b0;
        while (blur_sb.expected_blurs.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic program_regs(input bit [WEIGHT_W-1:0] c_w, input bit [WEIGHT_W-1:0] s_w,
                                input bit [WEIGHT_W-1:0] k_w, input bit [WIDTH_W-1:0] len);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= CFG_CENTER;
        i_cfg_wdata <= c_w;
        @(posedge i_clk);
        i_cfg_index <= CFG_EDGE;
        i_cfg_wdata <= s_w;
        @(posedge i_clk);
        i_cfg_index <= CFG_CORNER;
        i_cfg_wdata <= k_w;
        @(posedge i_clk);
        i_cfg_index <= CFG_WIDTH;
        i_cfg_wdata <= CFG_DATA_W'(len);
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        blur_sb.set_regs(c_w, s_w, k_w, len);
    endtask

    task automatic close_frame();
        while (!blur_sb.at_frame_start()) send_word(1'b1, 8'($urandom));
    endtask

    task automatic send_frame(input int rows);
        int len;
        len = blur_sb.row_len();
        repeat (rows) repeat (len) send_word(1'b0, rand_pixel());
        repeat (len) send_word(1'b1, 8'($urandom));
    endtask

    // Random words with scattered drains, then close whatever frame is left open.
    task automatic send_noise(input int count);
        repeat (count) send_word($urandom_range(5) == 0, rand_pixel());
        close_frame();
    endtask

    initial begin
        int base;
        int phase_start;
        int done;
        idle_mix(28, 58);
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        program_regs(CENTER_RESET, EDGE_RESET, CORNER_RESET, WIDTH_W'(3));
        send_word(1'b0, 8'd0);
        send_word(1'b0, 8'd255);
        send_word(1'b0, 8'd128);
        close_frame();
        // drain before any full image row: frame resets silently
        send_word(1'b1, 8'd44);
        send_word(1'b0, 8'd5);
        send_word(1'b0, 8'd6);
        // drain inside an image row makes it the drain row; later pixels count as given
        send_word(1'b0, 8'd9);
        send_word(1'b0, 8'd200);
        send_word(1'b0, 8'd77);
        send_word(1'b0, 8'd1);
        send_word(1'b1, 8'd13);
        send_word(1'b0, 8'd250);
        settle();
        // width 0 behaves as 1; full weights force the clamp
        program_regs('1, '1, '1, WIDTH_W'(0));
        send_word(1'b0, 8'd255);
        send_word(1'b0, 8'd7);
        send_word(1'b1, 8'd0);
        settle();
        program_regs('1, '0, '0, WIDTH_W'(6));
        repeat (4) send_word(1'b0, rand_pixel());
        // shrink the row while it is open: the next word closes it
        settle();
        program_regs('1, '0, '0, WIDTH_W'(2));
        send_word(1'b0, 8'd255);
        send_word(1'b0, 8'd128);
        send_word(1'b0, 8'd1);
        close_frame();
        // 2047 clips to the line store depth: a bare drain row spans 1024 words
        settle();
        program_regs(CENTER_RESET, EDGE_RESET, CORNER_RESET, '1);
        send_frame(0);

        base = words_sent;
        while (words_sent - base < RANDOM_WORDS) begin
            done = words_sent - base;
            if (done < RANDOM_WORDS / 3)
                idle_mix(28, 58);
            else if (done < 2 * RANDOM_WORDS / 3)
                idle_mix(58, 28);
            else
                idle_mix(0, 0);
            settle();
            program_regs(pick_weight(), pick_weight(), pick_weight(), pick_width());
            phase_start = words_sent;
            while (words_sent - phase_start < PHASE_WORDS) begin
                if ($urandom_range(3) != 0)
                    send_frame($urandom_range(1, 4));
                else
                    send_noise($urandom_range(1, 3 * blur_sb.row_len()));
            end
        end
        settle();

        if (blur_sb.errors == 0)
            $display("tb_top: PASS");
        else
            $display("tb_top: FAIL");
        $finish;
    end
endmodule
